@@ src/mds_pkg.sv @@
// ----------------------------------------------------------------------------
// mds_pkg: shared types, constants and the code table
// Symbol codes, code store limits, the front-to-back command and the lookup
// from a stored code to its ASCII character.
// ----------------------------------------------------------------------------
package mds_pkg;

   localparam int MAX_CODE_LEN = 7;
   localparam int STORE_LEN    = 7;
   localparam int CODE_LIMIT   = (MAX_CODE_LEN < STORE_LEN) ? MAX_CODE_LEN : STORE_LEN;
   localparam int LEN_W        = $clog2(STORE_LEN + 1);

   localparam logic [7:0] CHR_STAR  = 8'h2A;  // '*'
   localparam logic [7:0] CHR_DASH  = 8'h30;  // '0'
   localparam logic [7:0] CHR_DOT   = 8'h31;  // '1'
   localparam logic [7:0] CHR_SPACE = 8'h20;  // ' '
   localparam logic [7:0] CHR_END   = 8'h2D;  // '-'

   localparam logic MODE_SYMBOL = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // One command covers all results of one request.
   typedef struct packed {
      logic       has_char;
      logic [7:0] char_code;
      logic       has_space;
   } mds_cmd_type;

   // Element k at bit k, dash = 1. Bits above the length are always zero.
   function automatic logic [7:0] mds_lookup(input logic [LEN_W-1:0] len,
                                             input logic [STORE_LEN-1:0] bits);
      logic [7:0] ch;
      ch = CHR_STAR;
      unique case ({len, bits})
         {3'd1, 7'b0000000}: ch = "e";
         {3'd1, 7'b0000001}: ch = "t";
         {3'd2, 7'b0000000}: ch = "i";
         {3'd2, 7'b0000010}: ch = "a";
         {3'd2, 7'b0000001}: ch = "n";
         {3'd2, 7'b0000011}: ch = "m";
         {3'd3, 7'b0000000}: ch = "s";
         {3'd3, 7'b0000100}: ch = "u";
         {3'd3, 7'b0000010}: ch = "r";
         {3'd3, 7'b0000110}: ch = "w";
         {3'd3, 7'b0000001}: ch = "d";
         {3'd3, 7'b0000101}: ch = "k";
         {3'd3, 7'b0000011}: ch = "g";
         {3'd3, 7'b0000111}: ch = "o";
         {3'd4, 7'b0000000}: ch = "h";
         {3'd4, 7'b0001000}: ch = "v";
         {3'd4, 7'b0000100}: ch = "f";
         {3'd4, 7'b0000010}: ch = "l";
         {3'd4, 7'b0000110}: ch = "p";
         {3'd4, 7'b0001110}: ch = "j";
         {3'd4, 7'b0000001}: ch = "b";
         {3'd4, 7'b0001001}: ch = "x";
         {3'd4, 7'b0000101}: ch = "c";
         {3'd4, 7'b0001101}: ch = "y";
         {3'd4, 7'b0000011}: ch = "z";
         {3'd4, 7'b0001011}: ch = "q";
         {3'd5, 7'b0011111}: ch = "0";
         {3'd5, 7'b0011110}: ch = "1";
         {3'd5, 7'b0011100}: ch = "2";
         {3'd5, 7'b0011000}: ch = "3";
         {3'd5, 7'b0010000}: ch = "4";
         {3'd5, 7'b0000000}: ch = "5";
         {3'd5, 7'b0000001}: ch = "6";
         {3'd5, 7'b0000011}: ch = "7";
         {3'd5, 7'b0000111}: ch = "8";
         {3'd5, 7'b0001111}: ch = "9";
         {3'd5, 7'b0001001}: ch = "/";
         {3'd5, 7'b0001101}: ch = "(";
         {3'd5, 7'b0000010}: ch = "&";
         {3'd5, 7'b0010001}: ch = "=";
         {3'd5, 7'b0001010}: ch = "+";
         {3'd6, 7'b0101010}: ch = ".";
         {3'd6, 7'b0110011}: ch = ",";
         {3'd6, 7'b0001100}: ch = "?";
         {3'd6, 7'b0011110}: ch = "'";
         {3'd6, 7'b0110101}: ch = "!";
         {3'd6, 7'b0101101}: ch = ")";
         {3'd6, 7'b0000111}: ch = ":";
         {3'd6, 7'b0010101}: ch = ";";
         {3'd6, 7'b0100001}: ch = "-";
         {3'd6, 7'b0101100}: ch = "_";
         {3'd6, 7'b0010010}: ch = "\"";
         {3'd6, 7'b0010110}: ch = "@";
         {3'd7, 7'b1001000}: ch = "$";
         default:            ch = CHR_STAR;
      endcase
      return ch;
   endfunction

endpackage

@@ src/morse_symbol_decoder.sv @@
// ----------------------------------------------------------------------------
// morse_symbol_decoder: Morse symbol stream to ASCII characters
// Front stage keeps the element code and turns each request that yields a result into a command;
// a two-entry command queue feeds the back stage, which emits the results.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | req_push, req_full | req_mode (1), req_symbol (8)
//  result    | rsp_pop, rsp_empty | rsp_char_code (8), rsp_run_last (1)
//
//  A request is taken whenever the command queue has room; its
//  results leave one per cycle from the back stage's output register while
//  rsp_pop stays high, so a word gap after a pending code gives two results.
//  Sustained rate while rsp_pop stays high: one request per cycle, one result per cycle.
//  Reset (synchronous) empties the code store, queue and output register.
//  A stalled result side fills the queue and then raises req_full.
// ----------------------------------------------------------------------------
module morse_symbol_decoder import mds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_mode,
   input  logic [7:0] req_symbol,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_char_code,
   output logic       rsp_run_last
);

   logic        take;
   logic        cmd_push;
   mds_cmd_type front_cmd;
   logic        q_avail;
   logic        q_pop;
   mds_cmd_type q_head;

   // Request accepted only while the queue can take its command.
   assign take = req_push && !req_full;

   mds_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .mode     (req_mode),
      .symbol   (req_symbol),
      .cmd_push (cmd_push),
      .cmd      (front_cmd)
   );

   mds_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (q_pop),
      .avail    (q_avail),
      .head     (q_head)
   );

   mds_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_avail     (q_avail),
      .cmd           (q_head),
      .cmd_pop       (q_pop),
      .rsp_char_code (rsp_char_code),
      .rsp_run_last  (rsp_run_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

endmodule

@@ src/mds_front.sv @@
// ----------------------------------------------------------------------------
// mds_front: request intake and code store
// Classifies each request, updates the stored code and issues at most one command.
// ----------------------------------------------------------------------------
module mds_front import mds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic        mode,
   input  logic [7:0]  symbol,
   output logic        cmd_push,
   output mds_cmd_type cmd
);

   logic [STORE_LEN-1:0] code_bits_ff, code_bits_in;
   logic [LEN_W-1:0]     code_length_ff, code_length_in;
   logic                 code_overflow_ff, code_overflow_in;
   logic                 pending;
   logic                 at_limit;
   logic [7:0]           decoded;

   assign pending  = (code_length_ff != '0) || code_overflow_ff;
   assign at_limit = int'(code_length_ff) >= CODE_LIMIT;
   assign decoded  = (!code_overflow_ff && code_length_ff != '0)
                     ? mds_lookup(code_length_ff, code_bits_ff) : CHR_STAR;

   always_comb begin
      code_bits_in     = code_bits_ff;
      code_length_in   = code_length_ff;
      code_overflow_in = code_overflow_ff;
      cmd              = '{has_char: 1'b0, char_code: decoded, has_space: 1'b0};
      if (mode == MODE_FLUSH) begin
         cmd.has_char = pending;
         code_bits_in = '0; code_length_in = '0; code_overflow_in = 1'b0;
      end else if (symbol == CHR_DASH || symbol == CHR_DOT) begin
         if (at_limit) begin
            code_overflow_in = 1'b1;
         end else begin
            code_bits_in   = code_bits_ff
                             | ({{(STORE_LEN-1){1'b0}}, (symbol == CHR_DASH)} << code_length_ff);
            code_length_in = code_length_ff + 1'b1;
         end
      end else if (symbol == CHR_SPACE) begin
         cmd.has_char  = pending;
         cmd.has_space = 1'b1;
         code_bits_in = '0; code_length_in = '0; code_overflow_in = 1'b0;
      end else if (symbol == CHR_END) begin
         cmd.has_char = 1'b1;
         code_bits_in = '0; code_length_in = '0; code_overflow_in = 1'b0;
      end else begin
         cmd.has_char  = 1'b1;
         cmd.char_code = CHR_STAR;
         code_bits_in = '0; code_length_in = '0; code_overflow_in = 1'b0;
      end
   end

   assign cmd_push = take && (cmd.has_char || cmd.has_space);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff     <= '0;
         code_length_ff   <= '0;
         code_overflow_ff <= 1'b0;
      end else if (take) begin
         code_bits_ff     <= code_bits_in;
         code_length_ff   <= code_length_in;
         code_overflow_ff <= code_overflow_in;
      end
   end

endmodule

@@ src/mds_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// mds_cmd_fifo: command queue between front and back
// Short first-in first-out store; front and back stall independently.
// ----------------------------------------------------------------------------
module mds_cmd_fifo import mds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  mds_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        avail,
   output mds_cmd_type head
);

   mds_cmd_type          slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign avail   = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == CMD_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == CMD_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/mds_back.sv @@
// ----------------------------------------------------------------------------
// mds_back: result sequencer
// Expands each command into one or two results held in an output register.
// ----------------------------------------------------------------------------
module mds_back import mds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_avail,
   input  mds_cmd_type cmd,
   output logic        cmd_pop,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_run_last,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   logic       cur_valid_ff, cur_valid_in;
   logic       char_pend_ff, char_pend_in;
   logic       space_ff, space_in;
   logic [7:0] char_ff, char_in;
   logic       taken, finishing;

   assign rsp_empty     = !cur_valid_ff;
   assign rsp_char_code = char_pend_ff ? char_ff : CHR_SPACE;
   assign rsp_run_last  = char_pend_ff ? !space_ff : 1'b1;

   assign taken     = rsp_pop && cur_valid_ff;
   assign finishing = taken && rsp_run_last;
   assign cmd_pop   = cmd_avail && (!cur_valid_ff || finishing);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      char_pend_in = char_pend_ff;
      space_in     = space_ff;
      char_in      = char_ff;
      if (cmd_pop) begin
         cur_valid_in = 1'b1;
         char_pend_in = cmd.has_char;
         space_in     = cmd.has_space;
         char_in      = cmd.char_code;
      end else if (finishing) begin
         cur_valid_in = 1'b0;
      end else if (taken) begin
         char_pend_in = 1'b0;  // character gone, space still to send
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         char_pend_ff <= 1'b0;
         space_ff     <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         char_pend_ff <= char_pend_in;
         space_ff     <= space_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

endmodule

@@ dv/tb_morse_symbol_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_morse_symbol_decoder: self-checking bench for the Morse symbol decoder
// A short table of directed requests covers the empty, unknown, overflow and
// stray-byte cases, then mostly well-formed random letters with some noise.
// Every result is checked against an in-bench decoder model or the typed-in
// results of fixed rows, and both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb_morse_symbol_decoder import mds_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 1100;
   localparam int CALM_TAIL     = 200;     // last requests sent with no idling
   localparam int DRAIN_CYCLES  = 8;       // queue plus output register, with margin
   localparam int CYCLE_LIMIT   = 200000;
   localparam int N_PATTERNS    = 54;

   // One directed request; fixed rows carry their results typed in.
   typedef struct packed {
      logic       mode;
      logic [7:0] symbol;
      logic       fixed;
      logic [1:0] n_chars;
      logic [7:0] char0;
      logic [7:0] char1;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       run_last;
   } char_exp_type;

   // Directed table. Element bytes are inverted against the usual sense:
   // CHR_DASH ('0') is a dash and CHR_DOT ('1') is a dot.
   localparam stim_row_type DIRECTED_ROWS [24] = '{
      // flush with nothing stored: no result, symbol byte ignored
      '{MODE_FLUSH,  8'hFF,     1'b1, 2'd0, CHR_STAR,  CHR_STAR},
      // letter end with nothing stored
      '{MODE_SYMBOL, CHR_END,   1'b1, 2'd1, CHR_STAR,  CHR_STAR},
      // word gap with nothing stored: only the space
      '{MODE_SYMBOL, CHR_SPACE, 1'b1, 2'd1, CHR_SPACE, CHR_STAR},
      // one dot, then a stray byte wipes it
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, 8'h00,     1'b1, 2'd1, CHR_STAR,  CHR_STAR},
      // flush after the wipe: nothing left, and the dash byte must not append
      '{MODE_FLUSH,  CHR_DASH,  1'b1, 2'd0, CHR_STAR,  CHR_STAR},
      // "...-.." is not a letter
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DASH,  1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_END,   1'b1, 2'd1, CHR_STAR,  CHR_STAR},
      // fill the store with "...-..-", then one element too many
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DASH,  1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DASH,  1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_DOT,   1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      // overflowed code decodes to '*', then the space follows
      '{MODE_SYMBOL, CHR_SPACE, 1'b1, 2'd2, CHR_STAR,  CHR_SPACE},
      // a single dash after the overflow has been cleared
      '{MODE_SYMBOL, CHR_DASH,  1'b0, 2'd0, CHR_STAR,  CHR_STAR},
      '{MODE_SYMBOL, CHR_END,   1'b0, 2'd0, CHR_STAR,  CHR_STAR}
   };

   // Code book: patterns in '.'/'-' form and the matching characters.
   string morse_pat [N_PATTERNS] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..", "-----", ".----", "..---",
      "...--", "....-", ".....", "-....", "--...", "---..", "----.", ".-.-.-",
      "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.", "-.--.-",
      ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-", "..--.-",
      ".-..-.", "...-..-", ".--.-."
   };
   string morse_chr = "abcdefghijklmnopqrstuvwxyz0123456789.,?'!/()&:;=+-_\"$@";

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_push   = 1'b0;
   logic       req_mode   = MODE_SYMBOL;
   logic [7:0] req_symbol = 8'h00;
   logic       rsp_pop    = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [7:0] rsp_char_code;
   logic       rsp_run_last;

   // Model of the element store
   logic [STORE_LEN-1:0] pend_bits = '0;
   logic [LEN_W-1:0]     pend_len  = '0;
   logic                 pend_ovf  = 1'b0;

   char_exp_type expected_chars [$];
   int        mismatches  = 0;
   int        items_sent  = 0;
   int        cycle_count = 0;
   int        pop_stall   = 0;
   bit        idle_on     = 1'b1;

   morse_symbol_decoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_mode      (req_mode),
      .req_symbol    (req_symbol),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_char_code (rsp_char_code),
      .rsp_run_last  (rsp_run_last)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   function automatic bit pattern_matches(input string p);
      if (p.len() != pend_len)
         return 1'b0;
      for (int k = 0; k < p.len(); k++) begin
         if (pend_bits[k] != (p[k] == CHR_END))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Decode the stored code, then clear it (overflow too).
   function automatic logic [7:0] decode_pending();
      logic [7:0] ch;
      bit         hit;
      ch  = CHR_STAR;
      hit = 1'b0;
      if (!pend_ovf && pend_len != 0) begin
         for (int i = 0; i < N_PATTERNS && !hit; i++) begin
            if (pattern_matches(morse_pat[i])) begin
               ch  = morse_chr[i];
               hit = 1'b1;
            end
         end
      end
      pend_bits = '0;
      pend_len  = '0;
      pend_ovf  = 1'b0;
      return ch;
   endfunction

   // Past the limit the element is dropped and the overflow flag sticks.
   function automatic void append_element(input logic dash);
      if (pend_len >= CODE_LIMIT) begin
         pend_ovf = 1'b1;
      end else begin
         pend_bits[pend_len] = dash;
         pend_len            = pend_len + 1'b1;
      end
   endfunction

   // Returns the number of characters a request gives (0..2).
   function automatic int decode_request(input logic mode, input logic [7:0] sym,
                                         output logic [7:0] c0, output logic [7:0] c1);
      int n;
      n  = 0;
      c0 = CHR_STAR;
      c1 = CHR_STAR;
      if (mode == MODE_FLUSH) begin
         if (pend_len != 0 || pend_ovf) begin
            c0 = decode_pending();
            n  = 1;
         end
      end else begin
         case (sym)
            CHR_DASH: append_element(1'b1);
            CHR_DOT:  append_element(1'b0);
            CHR_SPACE: begin
               if (pend_len != 0 || pend_ovf) begin
                  c0 = decode_pending();
                  c1 = CHR_SPACE;
                  n  = 2;
               end else begin
                  c0 = CHR_SPACE;
                  n  = 1;
               end
            end
            CHR_END: begin
               c0 = decode_pending();
               n  = 1;
            end
            default: begin
               void'(decode_pending());
               n = 1;
            end
         endcase
      end
      return n;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Holds the request until taken, then books its characters in order.
   task automatic send_request(input stim_row_type row);
      int           n;
      logic [7:0]   c0, c1;
      char_exp_type e;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_push   <= 1'b1;
      req_mode   <= row.mode;
      req_symbol <= row.symbol;
      @(posedge clock);
      while (req_full) @(posedge clock);
      n = decode_request(row.mode, row.symbol, c0, c1);
      if (row.fixed) begin
         n  = row.n_chars;
         c0 = row.char0;
         c1 = row.char1;
      end
      for (int k = 0; k < n; k++) begin
         e.char_code = (k == 0) ? c0 : c1;
         e.run_last  = (k == n - 1);
         expected_chars.insert(expected_chars.size(), e);
      end
      // an empty flush does nothing, so it doesn't count
      if (!(row.mode == MODE_FLUSH && n == 0))
         items_sent++;
   endtask

   task automatic send_symbol(input logic mode, input logic [7:0] sym);
      stim_row_type row;
      row         = '0;
      row.mode    = mode;
      row.symbol  = sym;
      send_request(row);
   endtask

   // Close a letter: mostly letter end, some word gaps, a few flushes.
   task automatic send_terminator();
      int t;
      t = $urandom_range(0, 9);
      if (t < 5)
         send_symbol(MODE_SYMBOL, CHR_END);
      else if (t < 8)
         send_symbol(MODE_SYMBOL, CHR_SPACE);
      else
         send_symbol(MODE_FLUSH, 8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------
   // Result side: pop with random stall bursts, check in order
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (pop_stall != 0) begin
         rsp_pop   <= 1'b0;
         pop_stall <= pop_stall - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_pop   <= 1'b0;
         pop_stall <= $urandom_range(0, 4);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      char_exp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: char 0x%02h last %0b",
                        rsp_char_code, rsp_run_last);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.char_code || rsp_run_last !== want.run_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                           want.char_code, rsp_char_code, want.run_last, rsp_run_last);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_morse_symbol_decoder failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int    r;
      int    idx;
      int    target;
      string p;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_request(DIRECTED_ROWS[i]);

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         // idling switches on and off in stretches, and stops for the tail
         if (target - items_sent <= CALM_TAIL)
            idle_on = 1'b0;
         else if ($urandom_range(0, 15) == 0)
            idle_on = !idle_on;

         r = $urandom_range(0, 99);
         if (r < 70) begin
            // well-formed letter from the code book
            idx = $urandom_range(0, N_PATTERNS - 1);
            p   = morse_pat[idx];
            for (int k = 0; k < p.len(); k++)
               send_symbol(MODE_SYMBOL, (p[k] == CHR_END) ? CHR_DASH : CHR_DOT);
            send_terminator();
         end else if (r < 80) begin
            send_symbol(MODE_SYMBOL, 8'($urandom_range(0, 255)));
         end else if (r < 85) begin
            send_symbol(MODE_FLUSH, 8'($urandom_range(0, 255)));
         end else begin
            // random element run: unknown codes and overflow
            repeat ($urandom_range(0, 9))
               send_symbol(MODE_SYMBOL, $urandom_range(0, 1) ? CHR_DASH : CHR_DOT);
            send_terminator();
         end
      end
      req_push <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_chars.size() == 0)
         $display("tb_morse_symbol_decoder passed");
      else
         $display("tb_morse_symbol_decoder failed");
      $finish;
   end

endmodule

@@ filelist.f @@
src/mds_pkg.sv
src/mds_front.sv
src/mds_cmd_fifo.sv
src/mds_back.sv
src/morse_symbol_decoder.sv
dv/tb_morse_symbol_decoder.sv
